>>> sv/wavhp_pkg.sv
package wavhp_pkg;

    localparam logic [3:0] PH_RIFF    = 4'd0;
    localparam logic [3:0] PH_RSIZE   = 4'd1;
    localparam logic [3:0] PH_WAVE    = 4'd2;
    localparam logic [3:0] PH_FMTID   = 4'd3;
    localparam logic [3:0] PH_FMTLEN  = 4'd4;
    localparam logic [3:0] PH_FMTBODY = 4'd5;
    localparam logic [3:0] PH_FMTSKIP = 4'd6;
    localparam logic [3:0] PH_CKID    = 4'd7;
    localparam logic [3:0] PH_CKLEN   = 4'd8;
    localparam logic [3:0] PH_CKSKIP  = 4'd9;
    localparam logic [3:0] PH_DATA    = 4'd10;
    localparam logic [3:0] PH_TRAIL   = 4'd11;
    localparam logic [3:0] PH_ERR     = 4'd12;

    localparam logic [3:0] ST_HEADER      = 4'd0;
    localparam logic [3:0] ST_PAYLOAD     = 4'd1;
    localparam logic [3:0] ST_TRAILING    = 4'd2;
    localparam logic [3:0] ST_NOT_RIFF    = 4'd3;
    localparam logic [3:0] ST_NOT_WAVE    = 4'd4;
    localparam logic [3:0] ST_NO_FMT      = 4'd5;
    localparam logic [3:0] ST_UNSUPPORTED = 4'd6;
    localparam logic [3:0] ST_TRUNCATED   = 4'd7;
    localparam logic [3:0] ST_AFTER_ERROR = 4'd8;
    localparam logic [3:0] ST_IDLE        = 4'd9;

    localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
    localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
    localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
    localparam logic [31:0] TAG_DATA = 32'h6461_7461;

    localparam logic [31:0] FMT_BODY_LEN = 32'd16;
    localparam logic [15:0] PCM_BITS     = 16'd16;

    typedef struct packed {
        logic [3:0]  phase;
        logic [4:0]  byte_position;
        logic [31:0] tag_shift;
        logic [31:0] chunk_length;
        logic [31:0] bytes_left;
        logic [15:0] channel_count;
        logic [15:0] sample_bits;
        logic [31:0] rate_held;
    } state_t;

    localparam state_t STATE_RESET = '{
        phase:         PH_RIFF,
        byte_position: 5'd0,
        tag_shift:     32'd0,
        chunk_length:  32'd0,
        bytes_left:    32'd0,
        channel_count: 16'd0,
        sample_bits:   16'd0,
        rate_held:     32'd0
    };

    typedef struct packed {
        logic [3:0]  status;
        logic [7:0]  payload_byte;
        logic        payload_last;
        logic        stereo;
        logic [31:0] sample_rate;
    } result_t;

endpackage

>>> sv/wavhp_step.sv
module wavhp_step (
    input  wavhp_pkg::state_t  state,
    input  logic [7:0]         file_byte,
    input  logic               stream_end,
    output wavhp_pkg::state_t  state_next,
    output wavhp_pkg::result_t result
);

    wavhp_pkg::state_t s;
    logic [4:0]  pos_inc;
    logic        quad_done;
    logic [31:0] tag_in;
    logic [31:0] len_in;
    logic [31:0] left_dec;
    logic [3:0]  status;
    logic [7:0]  pbyte;
    logic        plast;

    assign pos_inc   = state.byte_position + 5'd1;
    assign quad_done = (pos_inc[4:2] != 3'd0);
    assign tag_in    = {state.tag_shift[23:0], file_byte};
    assign len_in    = {file_byte, state.chunk_length[31:8]};
    assign left_dec  = state.bytes_left - 32'd1;

    always_comb
    begin
        s      = state;
        status = wavhp_pkg::ST_HEADER;
        pbyte  = 8'd0;
        plast  = 1'b0;
        unique case (state.phase)
            wavhp_pkg::PH_RIFF, wavhp_pkg::PH_WAVE, wavhp_pkg::PH_FMTID,
            wavhp_pkg::PH_CKID:
            begin
                s.tag_shift     = tag_in;
                s.byte_position = quad_done ? 5'd0 : pos_inc;
                if (quad_done)
                begin
                    priority case (state.phase)
                        wavhp_pkg::PH_RIFF:
                        begin
                            if (tag_in == wavhp_pkg::TAG_RIFF)
                                s.phase = wavhp_pkg::PH_RSIZE;
                            else
                            begin
                                status  = wavhp_pkg::ST_NOT_RIFF;
                                s.phase = wavhp_pkg::PH_ERR;
                            end
                        end
                        wavhp_pkg::PH_WAVE:
                        begin
                            if (tag_in == wavhp_pkg::TAG_WAVE)
                                s.phase = wavhp_pkg::PH_FMTID;
                            else
                            begin
                                status  = wavhp_pkg::ST_NOT_WAVE;
                                s.phase = wavhp_pkg::PH_ERR;
                            end
                        end
                        wavhp_pkg::PH_FMTID:
                        begin
                            if (tag_in == wavhp_pkg::TAG_FMT)
                                s.phase = wavhp_pkg::PH_FMTLEN;
                            else
                            begin
                                status  = wavhp_pkg::ST_NO_FMT;
                                s.phase = wavhp_pkg::PH_ERR;
                            end
                        end
                        default:
                            s.phase = wavhp_pkg::PH_CKLEN;
                    endcase
                end
            end
            wavhp_pkg::PH_RSIZE, wavhp_pkg::PH_FMTLEN, wavhp_pkg::PH_CKLEN:
            begin
                s.chunk_length  = len_in;
                s.byte_position = quad_done ? 5'd0 : pos_inc;
                if (quad_done)
                begin
                    priority case (state.phase)
                        wavhp_pkg::PH_RSIZE:
                            s.phase = wavhp_pkg::PH_WAVE;
                        wavhp_pkg::PH_FMTLEN:
                        begin
                            s.bytes_left = (len_in > wavhp_pkg::FMT_BODY_LEN)
                                ? len_in - wavhp_pkg::FMT_BODY_LEN : 32'd0;
                            s.phase = wavhp_pkg::PH_FMTBODY;
                        end
                        default:
                        begin
                            s.bytes_left = len_in;
                            if (state.tag_shift == wavhp_pkg::TAG_DATA)
                            begin
                                if (len_in == 32'd0)
                                begin
                                    status  = wavhp_pkg::ST_IDLE;
                                    s.phase = wavhp_pkg::PH_TRAIL;
                                end
                                else
                                    s.phase = wavhp_pkg::PH_DATA;
                            end
                            else
                                s.phase = (len_in != 32'd0) ? wavhp_pkg::PH_CKSKIP
                                                             : wavhp_pkg::PH_CKID;
                        end
                    endcase
                end
            end
            wavhp_pkg::PH_FMTBODY:
            begin
                if (state.byte_position == 5'd2 || state.byte_position == 5'd3)
                    s.channel_count = {file_byte, state.channel_count[15:8]};
                else if (state.byte_position >= 5'd4 && state.byte_position <= 5'd7)
                    s.rate_held = {file_byte, state.rate_held[31:8]};
                else if (state.byte_position == 5'd14 || state.byte_position == 5'd15)
                    s.sample_bits = {file_byte, state.sample_bits[15:8]};
                s.byte_position = pos_inc;
                if (pos_inc[4])
                begin
                    s.byte_position = 5'd0;
                    if ((s.channel_count != 16'd1 && s.channel_count != 16'd2)
                        || s.sample_bits != wavhp_pkg::PCM_BITS)
                    begin
                        status  = wavhp_pkg::ST_UNSUPPORTED;
                        s.phase = wavhp_pkg::PH_ERR;
                    end
                    else
                        s.phase = (state.bytes_left != 32'd0) ? wavhp_pkg::PH_FMTSKIP
                                                               : wavhp_pkg::PH_CKID;
                end
            end
            wavhp_pkg::PH_FMTSKIP, wavhp_pkg::PH_CKSKIP:
            begin
                s.bytes_left = left_dec;
                if (left_dec == 32'd0)
                    s.phase = wavhp_pkg::PH_CKID;
            end
            wavhp_pkg::PH_DATA:
            begin
                s.bytes_left = left_dec;
                status       = wavhp_pkg::ST_PAYLOAD;
                pbyte        = file_byte;
                if (left_dec == 32'd0)
                begin
                    plast   = 1'b1;
                    s.phase = wavhp_pkg::PH_TRAIL;
                end
            end
            wavhp_pkg::PH_TRAIL:
                status = wavhp_pkg::ST_TRAILING;
            default:
                status = wavhp_pkg::ST_AFTER_ERROR;
        endcase

        // early end of file: header or mid-payload byte is truncation
        if (stream_end && (status == wavhp_pkg::ST_HEADER
            || (status == wavhp_pkg::ST_PAYLOAD && !plast)))
        begin
            status = wavhp_pkg::ST_TRUNCATED;
            pbyte  = 8'd0;
            plast  = 1'b0;
        end

        result.status       = status;
        result.payload_byte = pbyte;
        result.payload_last = plast;
        result.stereo       = (s.channel_count == 16'd2);
        result.sample_rate  = s.rate_held;

        state_next = stream_end ? wavhp_pkg::STATE_RESET : s;
    end

endmodule

>>> sv/wav_header_parser_unit.sv
// RIFF/WAVE header parser, 16-bit PCM mono or stereo.
// Input channel: one file byte per item (file_byte, stream_end) on
// in_valid/in_ready. Output channel: one result item per input item
// (status, payload_byte, payload_last, stereo, sample_rate) on
// out_valid/out_ready.
// Latency: result is valid the cycle after the input item is accepted.
// Throughput: one item per cycle while the receiver does not stall; the
// parse state is updated in the same cycle the byte is accepted, with a
// few 32-bit compares, one 32-bit decrement and one 32-bit subtract in
// the path to the state and result registers.
// When the receiver stalls, the result stays in the output register and
// in_ready drops until it is taken; in_ready is high while the output
// register is empty or being drained.
// Reset puts the parser in the wait-for-RIFF phase with all captured
// fields cleared and the output register empty. An item with
// stream_end set reports its result and then re-arms the parser.
module wav_header_parser_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  file_byte,
    input  logic        stream_end,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [3:0]  status,
    output logic [7:0]  payload_byte,
    output logic        payload_last,
    output logic        stereo,
    output logic [31:0] sample_rate
);

    wavhp_pkg::state_t  state_reg;
    wavhp_pkg::state_t  state_next;
    wavhp_pkg::result_t result_reg;
    wavhp_pkg::result_t result_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic               in_fire;

    assign in_ready       = !out_valid_reg || out_ready;
    assign in_fire        = in_valid && in_ready;
    assign out_valid_next = in_fire || (out_valid_reg && !out_ready);

    wavhp_step u_step (
        .state      (state_reg),
        .file_byte  (file_byte),
        .stream_end (stream_end),
        .state_next (state_next),
        .result     (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= wavhp_pkg::STATE_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (in_fire)
                state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
            result_reg <= result_next;
    end

    assign out_valid    = out_valid_reg;
    assign status       = result_reg.status;
    assign payload_byte = result_reg.payload_byte;
    assign payload_last = result_reg.payload_last;
    assign stereo       = result_reg.stereo;
    assign sample_rate  = result_reg.sample_rate;

endmodule
